// ===== sv/c32s_pkg.sv =====
// ============================================================================
// c32s_pkg
// Constants and the per-byte update function shared by the CRC-32 stream unit.
// ============================================================================
`default_nettype none

package c32s_pkg;

    // Reflected CRC-32 generator (0x04C11DB7 taken LSB first)
    localparam logic [31:0] CRC_POLY_REFL = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ALL_ONES  = 32'hFFFF_FFFF;
    localparam int          BYTE_BITS     = 8;

    // One byte through the reflected shift register, LSB first.
    // Flattens into a fixed XOR network.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  byte_in);
        logic [31:0] acc;
        acc = crc_in ^ {24'h0, byte_in};
        for (int b = 0; b < BYTE_BITS; b++) begin
            if (acc[0])
                acc = (acc >> 1) ^ CRC_POLY_REFL;
            else
                acc = acc >> 1;
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// ===== sv/crc32_stream_8byte_unit.sv =====
// ============================================================================
// crc32_stream_8byte_unit
// Streaming reflected CRC-32 over up to eight bytes per transfer.
// ============================================================================
// Usage:
//   Slave side carries data_word and byte_count in s_tdata, start_req in
//   s_tuser. A set start_req reloads the CRC to all ones before the bytes of
//   that transfer; byte 0 (bits 7:0) goes in first, counts above
//   BYTES_PER_ITEM saturate, bytes beyond the count are ignored.
//   Every input transfer yields one master transfer with the finished CRC
//   (running value inverted) after its bytes.
//   Path: the input transfer is written into the queue, from which the
//   engine takes it into its output register, which drives m_tvalid.
//   Throughput: one transfer per cycle while the receiver takes results; the CRC
//   register update through the engine's byte-wise XOR network is the loop that sets it.
//   A two-entry queue separates input side and engine, and the engine's
//   output register parts the engine from the receiver.
//   Receiver stall: the result holds, the queue fills, and s_tready falls
//   once both entries are taken; nothing is dropped.
//   Reset: CRC register goes to all ones, queue and output empty.
// ============================================================================
`default_nettype none

module crc32_stream_8byte_unit #(
    parameter int BYTES_PER_ITEM = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [71:0] s_tdata,   // data_word[63:0], byte_count[67:64], zero[71:68]
    input  wire logic [0:0]  s_tuser,   // start_req[0]
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [31:0] m_tdata    // crc_value[31:0]
);

    localparam int DATA_W  = BYTES_PER_ITEM * 8;
    localparam int COUNT_W = $clog2(BYTES_PER_ITEM + 1);
    localparam int ENTRY_W = 1 + COUNT_W + DATA_W;

    logic                push_valid, push_ready;
    logic                pop_valid, pop_ready;
    logic                in_start, out_start;
    logic [COUNT_W-1:0]  in_count, out_count;
    logic [DATA_W-1:0]   in_data, out_data;
    logic [ENTRY_W-1:0]  push_entry, pop_entry;

    c32s_front #(
        .BYTES_PER_ITEM (BYTES_PER_ITEM),
        .COUNT_W        (COUNT_W)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .item_start (in_start),
        .item_count (in_count),
        .item_data  (in_data)
    );

    // Pack queue entry
    assign push_entry = {in_start, in_count, in_data};

    c32s_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_entry)
    );

    assign out_start = pop_entry[ENTRY_W-1];
    assign out_count = pop_entry[DATA_W +: COUNT_W];
    assign out_data  = pop_entry[DATA_W-1:0];

    c32s_back #(
        .BYTES_PER_ITEM (BYTES_PER_ITEM),
        .COUNT_W        (COUNT_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .item_start (out_start),
        .item_count (out_count),
        .item_data  (out_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

// ===== sv/c32s_front.sv =====
// ============================================================================
// c32s_front
// Input side: takes transfers, clamps the byte count and passes the data on.
// ============================================================================
`default_nettype none

module c32s_front #(
    parameter int BYTES_PER_ITEM = 8,
    parameter int COUNT_W        = 4
) (
    input  wire logic                        s_tvalid,
    output      logic                        s_tready,
    input  wire logic [71:0]                 s_tdata,  // data_word[63:0], byte_count[67:64]
    input  wire logic [0:0]                  s_tuser,  // start_req[0]
    // toward the queue
    output      logic                        push_valid,
    input  wire logic                        push_ready,
    output      logic                        item_start,
    output      logic [COUNT_W-1:0]          item_count,
    output      logic [BYTES_PER_ITEM*8-1:0] item_data
);

    logic [3:0] count_raw;

    assign count_raw = s_tdata[67:64];

    // Handshake passes straight to the queue
    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

    // Counts above the item width saturate
    always_comb
    begin
        if (count_raw > 4'(BYTES_PER_ITEM))
            item_count = COUNT_W'(BYTES_PER_ITEM);
        else
            item_count = COUNT_W'(count_raw);
    end

    assign item_start = s_tuser[0];
    assign item_data  = s_tdata[BYTES_PER_ITEM*8-1:0];

endmodule

`default_nettype wire

// ===== sv/c32s_queue.sv =====
// ============================================================================
// c32s_queue
// Two-entry FIFO between the input side and the CRC engine.
// ============================================================================
`default_nettype none

module c32s_queue #(
    parameter int WIDTH = 73
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output      logic             push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output      logic             pop_valid,
    input  wire logic             pop_ready,
    output      logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       fill_reg, fill_next;
    logic             do_push, do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + 2'd1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== sv/c32s_back.sv =====
// ============================================================================
// c32s_back
// CRC engine: folds one item per cycle unless stalled and holds the result.
// ============================================================================
`default_nettype none

module c32s_back #(
    parameter int BYTES_PER_ITEM = 8,
    parameter int COUNT_W        = 4
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        pop_valid,
    output      logic                        pop_ready,
    input  wire logic                        item_start,
    input  wire logic [COUNT_W-1:0]          item_count,
    input  wire logic [BYTES_PER_ITEM*8-1:0] item_data,
    output      logic                        m_tvalid,
    input  wire logic                        m_tready,
    output      logic [31:0]                 m_tdata   // crc_value[31:0]
);

    import c32s_pkg::*;

    logic [31:0] crc_reg, crc_next;
    logic [31:0] result_reg;
    logic        out_valid_reg, out_valid_next;
    logic        take;

    // Take an item whenever the output register is free or draining
    assign pop_ready = !out_valid_reg || m_tready;
    assign take      = pop_valid && pop_ready;

    // Byte-wise XOR network over the valid bytes
    always_comb
    begin
        crc_next = item_start ? CRC_ALL_ONES : crc_reg;
        for (int k = 0; k < BYTES_PER_ITEM; k++) begin
            if (k < int'(item_count))
                crc_next = crc_byte(crc_next, item_data[k*8 +: 8]);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CRC_ALL_ONES;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                crc_reg <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Finished value, inverted
    always_ff @(posedge clk)
    begin
        if (take)
            result_reg <= crc_next ^ CRC_ALL_ONES;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

endmodule

`default_nettype wire

// ===== sv/c32s_checker.sv =====
// ============================================================================
// c32s_checker
// Port-level checks for the CRC-32 stream unit, bound to the top level.
// ============================================================================
`default_nettype none

module c32s_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // Stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transfer withdrawn under stall");

    // Stalled result keeps its value
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed under stall");

    // Every input transfer shows a result once it has passed queue and output register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("no result two cycles after input transfer");

    // Input back-pressure only arises behind a waiting result
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

endmodule

bind crc32_stream_8byte_unit c32s_checker u_checker (.*);

`default_nettype wire
